FILE: rtl/core/csmb_pkg.sv
// Shared types and constants of the sparse row matrix builder and lookup unit.
package csmb_pkg;

  localparam int unsigned MaxRows    = 64;
  localparam int unsigned MaxCols    = 64;
  localparam int unsigned MaxEntries = 1024;

  localparam int unsigned EntryAw = $clog2(MaxEntries);
  localparam int unsigned CountW  = 11;
  localparam int unsigned RowAw   = $clog2(MaxRows + 1);
  localparam int unsigned DimW    = 7;
  localparam int unsigned IdxW    = 6;
  localparam int unsigned WordW   = 32;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [0:0] {
    MODE_APPEND = 1'b0,
    MODE_LOOKUP = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_RANGE     = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_EXHAUSTED = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_NUM_ROWS = 2'd0,
    CFG_NUM_COLS = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [0:0]      mode;
    logic [WordW-1:0] element_word;
    logic [IdxW-1:0]  row_index;
    logic [IdxW-1:0]  col_index;
  } cmd_t;

  typedef struct packed {
    logic [WordW-1:0]  read_word;
    logic              found;
    status_e           status;
    logic [CountW-1:0] total_nonzeros;
    logic [DimW-1:0]   rows_filled;
  } res_t;

  typedef struct packed {
    logic               we;
    logic [EntryAw-1:0] addr;
    logic [WordW-1:0]   value;
    logic [IdxW-1:0]    col;
  } entry_wr_t;

  typedef struct packed {
    logic [WordW-1:0] value;
    logic [IdxW-1:0]  col;
  } entry_rd_t;

  typedef struct packed {
    logic              we;
    logic [RowAw-1:0]  addr;
    logic [CountW-1:0] data;
  } ptr_wr_t;

endpackage

FILE: rtl/core/csr_sparse_matrix_build_lookup_unit.sv
// Top level: command sequencer, counters and configuration of the sparse row matrix unit.
// Append: the result strobe follows in the next cycle; back-to-back appends allowed.
// Lookup out of bounds: result in the next cycle. Valid lookup: reads the row's start and
// end offsets (ST_PTR0, ST_PTR1), then scans its entries (at most 64), one read per cycle.
// Results are strobed for one cycle on done_o; the receiver cannot stall them.
// Reset clears counters and sets both dimensions to 64; the stores need no clearing pass.
module csr_sparse_matrix_build_lookup_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  csmb_pkg::cmd_t                   cmd_i,
  output logic                             busy_o,
  output logic                             done_o,
  output csmb_pkg::res_t                   res_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [csmb_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [csmb_pkg::DimW-1:0]        cfg_data_i
);

  localparam int unsigned CountW  = csmb_pkg::CountW;
  localparam int unsigned DimW    = csmb_pkg::DimW;
  localparam int unsigned IdxW    = csmb_pkg::IdxW;
  localparam int unsigned RowAw   = csmb_pkg::RowAw;
  localparam int unsigned EntryAw = csmb_pkg::EntryAw;

  localparam logic [DimW-1:0]   RowsMax    = DimW'(csmb_pkg::MaxRows);
  localparam logic [DimW-1:0]   ColsMax    = DimW'(csmb_pkg::MaxCols);
  localparam logic [CountW-1:0] EntriesMax = CountW'(csmb_pkg::MaxEntries);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PTR0 = 4'b0010,
    ST_PTR1 = 4'b0100,
    ST_SCAN = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [DimW-1:0]   num_rows_q, num_cols_q;
  logic [DimW-1:0]   rows_done_q, rows_done_d;
  logic [IdxW-1:0]   col_pos_q, col_pos_d;
  logic [CountW-1:0] entry_count_q, entry_count_d;
  logic [IdxW-1:0]   ri_q, ri_d, ci_q, ci_d;
  logic [CountW-1:0] k_q, k_d, end_q, end_d;
  logic              done_q, done_d;
  csmb_pkg::res_t    res_q, res_d;

  logic [DimW-1:0]   rows, cols;
  logic              accept;

  csmb_pkg::entry_wr_t        ent_wr;
  csmb_pkg::entry_rd_t        ent_rd;
  csmb_pkg::ptr_wr_t          ptr_wr;
  logic [RowAw-1:0]           ptr_rd_addr;
  logic [CountW-1:0]          ptr_rd_data;

  csmb_entry_mem u_entry_mem (
    .clk_i     (clk_i),
    .wr_i      (ent_wr),
    .rd_addr_i (k_q[EntryAw-1:0]),
    .rd_o      (ent_rd)
  );

  csmb_rowptr_mem u_rowptr_mem (
    .clk_i     (clk_i),
    .wr_i      (ptr_wr),
    .rd_addr_i (ptr_rd_addr),
    .rd_data_o (ptr_rd_data)
  );

  // Register values of zero act as one, values above the maximum as the maximum.
  assign rows = (num_rows_q == '0) ? DimW'(1) : ((num_rows_q > RowsMax) ? RowsMax : num_rows_q);
  assign cols = (num_cols_q == '0) ? DimW'(1) : ((num_cols_q > ColsMax) ? ColsMax : num_cols_q);

  assign busy_o      = (state_q != ST_IDLE);
  assign accept      = start_i && !busy_o;
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= RowsMax;
      num_cols_q <= ColsMax;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        csmb_pkg::CFG_NUM_ROWS: num_rows_q <= cfg_data_i;
        csmb_pkg::CFG_NUM_COLS: num_cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Appends and lookups never overlap, so the entry memory needs no forwarding.
  always_comb begin
    state_d       = state_q;
    rows_done_d   = rows_done_q;
    col_pos_d     = col_pos_q;
    entry_count_d = entry_count_q;
    ri_d          = ri_q;
    ci_d          = ci_q;
    k_d           = k_q;
    end_d         = end_q;
    done_d        = 1'b0;
    res_d         = res_q;
    ent_wr        = '{we: 1'b0, addr: entry_count_q[EntryAw-1:0],
                      value: cmd_i.element_word, col: col_pos_q};
    ptr_wr        = '{we: 1'b0, addr: rows_done_q + RowAw'(1), data: entry_count_q};
    ptr_rd_addr   = {1'b0, cmd_i.row_index};

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          done_d               = (cmd_i.mode == csmb_pkg::MODE_APPEND);
          res_d.read_word      = '0;
          res_d.found          = 1'b0;
          res_d.status         = csmb_pkg::STATUS_OK;
          if (cmd_i.mode == csmb_pkg::MODE_APPEND) begin
            if (rows_done_q >= rows) begin
              res_d.status = csmb_pkg::STATUS_EXHAUSTED;
            end else begin
              if (cmd_i.element_word[30:0] != '0) begin
                if (entry_count_q == EntriesMax) begin
                  res_d.status = csmb_pkg::STATUS_FULL;
                end else begin
                  ent_wr.we     = 1'b1;
                  entry_count_d = entry_count_q + CountW'(1);
                end
              end
              if ({1'b0, col_pos_q} + DimW'(1) >= cols) begin
                rows_done_d = rows_done_q + DimW'(1);
                ptr_wr.we   = 1'b1;
                ptr_wr.data = entry_count_d;
                col_pos_d   = '0;
              end else begin
                col_pos_d = col_pos_q + IdxW'(1);
              end
            end
          end else begin
            ri_d = cmd_i.row_index;
            ci_d = cmd_i.col_index;
            if (({1'b0, cmd_i.row_index} >= rows) || ({1'b0, cmd_i.col_index} >= cols) ||
                ({1'b0, cmd_i.row_index} >= rows_done_q)) begin
              res_d.status = csmb_pkg::STATUS_RANGE;
              done_d       = 1'b1;
            end else begin
              state_d = ST_PTR0;
            end
          end
          res_d.total_nonzeros = entry_count_d;
          res_d.rows_filled    = rows_done_d;
        end
      end
      ST_PTR0: begin
        k_d         = ptr_rd_data;
        ptr_rd_addr = {1'b0, ri_q} + RowAw'(1);
        state_d     = ST_PTR1;
      end
      ST_PTR1: begin
        end_d = ptr_rd_data;
        if (k_q < ptr_rd_data) begin
          k_d     = k_q + CountW'(1);
          state_d = ST_SCAN;
        end else begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // The word on the read port belongs to entry k_q - 1.
        if (ent_rd.col == ci_q) begin
          res_d.read_word = ent_rd.value;
          res_d.found     = 1'b1;
          done_d          = 1'b1;
          state_d         = ST_IDLE;
        end else if (k_q < end_q) begin
          k_d = k_q + CountW'(1);
        end else begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      rows_done_q   <= '0;
      col_pos_q     <= '0;
      entry_count_q <= '0;
      done_q        <= 1'b0;
    end else begin
      state_q       <= state_d;
      rows_done_q   <= rows_done_d;
      col_pos_q     <= col_pos_d;
      entry_count_q <= entry_count_d;
      done_q        <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ri_q  <= ri_d;
    ci_q  <= ci_d;
    k_q   <= k_d;
    end_q <= end_d;
    res_q <= res_d;
  end

  a_no_write_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ent_wr.we || ptr_wr.we) |-> (state_q == ST_IDLE))
    else $error("store written during a lookup");

  a_append_result_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i.mode == csmb_pkg::MODE_APPEND) |=> done_o)
    else $error("append result missing");

  a_found_is_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.found) |-> (res_o.status == csmb_pkg::STATUS_OK))
    else $error("hit reported with error status");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_count_q <= EntriesMax)
    else $error("entry count past store size");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (k_q <= end_q))
    else $error("scan ran past row end");

endmodule

FILE: rtl/core/csmb_entry_mem.sv
// Entry store: value word and column of each stored nonzero, one synchronous port pair.
module csmb_entry_mem (
  input  logic                             clk_i,
  input  csmb_pkg::entry_wr_t              wr_i,
  input  logic [csmb_pkg::EntryAw-1:0]     rd_addr_i,
  output csmb_pkg::entry_rd_t              rd_o
);

  csmb_pkg::entry_rd_t mem_q [csmb_pkg::MaxEntries];

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= '{value: wr_i.value, col: wr_i.col};
    end
    rd_o <= mem_q[rd_addr_i];
  end

endmodule

FILE: rtl/core/csmb_rowptr_mem.sv
// Row-start table: offset of the first entry of each row, entry zero reads as zero.
module csmb_rowptr_mem (
  input  logic                            clk_i,
  input  csmb_pkg::ptr_wr_t               wr_i,
  input  logic [csmb_pkg::RowAw-1:0]      rd_addr_i,
  output logic [csmb_pkg::CountW-1:0]     rd_data_o
);

  logic [csmb_pkg::CountW-1:0] mem_q [csmb_pkg::MaxRows + 1];
  logic [csmb_pkg::CountW-1:0] rd_q;
  logic                        rd_zero_q;

  // Entry zero is never written; the first row always starts at offset zero.
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_q      <= mem_q[rd_addr_i];
    rd_zero_q <= (rd_addr_i == '0);
  end

  assign rd_data_o = rd_zero_q ? '0 : rd_q;

endmodule
